// ===== hdl/skset_pkg.sv =====
package skset_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_SEARCH = 2'd2;

  localparam logic [1:0] STATUS_DONE = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] key;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [6:0]         count;
    logic signed [31:0] smallest_key;
    logic signed [31:0] largest_key;
    logic               is_empty;
  } rsp_t;

endpackage

// ===== hdl/sorted_key_set.sv =====
// Ordered set of up to CAPACITY distinct signed 32-bit keys, held ascending in one
// synchronous RAM (one write port, two registered read ports). Each request runs
// alone: a binary search over the held keys spends a read state and a compare state
// on each probe, because each probe waits on the RAM read. An insert then moves
// every key above the slot up by one and a delete moves them down, with a read and a
// write state per moved key through the single write port; an insert then places the
// new key in one more write state. A final read state and an output state read the
// first and last entry for the response, the output state waiting while a held response
// is stalled. A new request is taken only when the previous one has finished; a
// response may still sit in the output register while the next one starts.
module sorted_key_set
  import skset_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SRCH_RD  = 3'd1;
  localparam logic [2:0] S_SRCH_CMP = 3'd2;
  localparam logic [2:0] S_SH_RD    = 3'd3;
  localparam logic [2:0] S_SH_WR    = 3'd4;
  localparam logic [2:0] S_PUT      = 3'd5;
  localparam logic [2:0] S_FIN_RD   = 3'd6;
  localparam logic [2:0] S_FIN_OUT  = 3'd7;

  logic [31:0] mem [CAPACITY];

  logic [2:0]         state, state_next;
  logic [CW-1:0]      key_count, key_count_next;
  logic [CW-1:0]      lo, lo_next, hi, hi_next, idx, idx_next;
  logic [AW-1:0]      mid, mid_next;
  logic               hit, hit_next;
  logic [1:0]         func, func_next, status, status_next;
  logic signed [31:0] key, key_next;

  logic               we;
  logic [AW-1:0]      wa, ra, rb;
  logic [31:0]        wd, rd_a, rd_b;
  logic [CW:0]        mid_sum;
  logic [CW-1:0]      last_pos;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  assign req_stall = (state != S_IDLE);
  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign last_pos  = key_count - CW'(1);

  always_comb begin
    state_next     = state;
    key_count_next = key_count;
    lo_next        = lo;
    hi_next        = hi;
    idx_next       = idx;
    mid_next       = mid;
    hit_next       = hit;
    func_next      = func;
    status_next    = status;
    key_next       = key;
    we             = 1'b0;
    wa             = idx[AW-1:0];
    wd             = rd_a;
    ra             = mid;
    rb             = last_pos[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          func_next   = req.func;
          key_next    = req.key;
          lo_next     = '0;
          hi_next     = key_count;
          hit_next    = 1'b0;
          status_next = STATUS_DONE;
          state_next  = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (lo < hi) begin
          mid_next   = mid_sum[AW:1];
          ra         = mid_sum[AW:1];
          state_next = S_SRCH_CMP;
        end else if (func == FUNC_INSERT) begin
          // lo is the ordered slot of the key
          if (hit) begin
            status_next = STATUS_MISS;
            state_next  = S_FIN_RD;
          end else if (key_count >= CW'(CAPACITY)) begin
            status_next = STATUS_FULL;
            state_next  = S_FIN_RD;
          end else begin
            idx_next   = key_count;
            state_next = (key_count > lo) ? S_SH_RD : S_PUT;
          end
        end else if (func == FUNC_DELETE) begin
          if (!hit) begin
            status_next = STATUS_MISS;
            state_next  = S_FIN_RD;
          end else begin
            idx_next = lo;
            if ({1'b0, lo} + {{CW{1'b0}}, 1'b1} < {1'b0, key_count}) begin
              state_next = S_SH_RD;
            end else begin
              key_count_next = key_count - CW'(1);
              state_next     = S_FIN_RD;
            end
          end
        end else begin
          status_next = hit ? STATUS_DONE : STATUS_MISS;
          state_next  = S_FIN_RD;
        end
      end
      S_SRCH_CMP: begin
        if ($signed(rd_a) < key) begin
          lo_next = CW'(mid) + CW'(1);
        end else begin
          hi_next = CW'(mid);
        end
        if ($signed(rd_a) == key) begin
          hit_next = 1'b1;
        end
        state_next = S_SRCH_RD;
      end
      S_SH_RD: begin
        if (func == FUNC_INSERT) begin
          ra = AW'(idx - CW'(1));
        end else begin
          ra = AW'({1'b0, idx} + {{CW{1'b0}}, 1'b1});
        end
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        we = 1'b1;
        if (func == FUNC_INSERT) begin
          idx_next   = idx - CW'(1);
          state_next = (idx - CW'(1) > lo) ? S_SH_RD : S_PUT;
        end else begin
          idx_next = idx + CW'(1);
          if ({1'b0, idx} + (CW+1)'(2) < {1'b0, key_count}) begin
            state_next = S_SH_RD;
          end else begin
            key_count_next = key_count - CW'(1);
            state_next     = S_FIN_RD;
          end
        end
      end
      S_PUT: begin
        we             = 1'b1;
        wa             = lo[AW-1:0];
        wd             = key;
        key_count_next = key_count + CW'(1);
        state_next     = S_FIN_RD;
      end
      S_FIN_RD: begin
        ra         = '0;
        state_next = S_FIN_OUT;
      end
      S_FIN_OUT: begin
        // hold the read addresses so the end keys stay put while waiting
        ra = '0;
        if (!rsp_valid || !rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      key_count <= '0;
    end else begin
      state     <= state_next;
      key_count <= key_count_next;
    end
    lo     <= lo_next;
    hi     <= hi_next;
    idx    <= idx_next;
    mid    <= mid_next;
    hit    <= hit_next;
    func   <= func_next;
    status <= status_next;
    key    <= key_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_FIN_OUT && (!rsp_valid || !rsp_stall)) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN_OUT && (!rsp_valid || !rsp_stall)) begin
      rsp.status <= status;
      rsp.count  <= 7'(key_count);
      if (key_count == '0) begin
        rsp.smallest_key <= '0;
        rsp.largest_key  <= '0;
        rsp.is_empty     <= 1'b1;
      end else begin
        rsp.smallest_key <= rd_a;
        rsp.largest_key  <= rd_b;
        rsp.is_empty     <= 1'b0;
      end
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import skset_pkg::*;

  localparam int KEY_CAPACITY = CAPACITY_DEF;
  localparam logic [1:0] FUNC_SPARE = 2'd3;  // unused code, behaves as a search
  localparam int CYCLE_LIMIT = 600_000;
  localparam int SETTLE_CYCLES = 200;
  localparam int POOL_SIZE = 96;

  localparam int MODE_FILL  = 0;
  localparam int MODE_MIXED = 1;
  localparam int MODE_DRAIN = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  logic signed [31:0] held_keys[$];  // mirror of the store, ascending
  rsp_t set_rsp_q[$];                // responses still owed by the block
  logic signed [31:0] key_pool[POOL_SIZE];

  int fail_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int hold_off_cycles = 0;

  sorted_key_set #(
    .CAPACITY(KEY_CAPACITY)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses pending", cycle_count,
               set_rsp_q.size());
      $display("** sorted_key_set: FAILED **");
      $finish;
    end
  end

  // Applies one operation to the mirrored set and returns the response it owes.
  function automatic rsp_t apply_set_op(input req_t r);
    int pos;
    bit hit;
    rsp_t o;
    logic signed [31:0] k;
    k = r.key;
    pos = 0;
    while (pos < held_keys.size() && held_keys[pos] < k) pos++;
    hit = (pos < held_keys.size()) && (held_keys[pos] == k);
    o = '0;
    case (r.func)
      FUNC_INSERT: begin
        if (hit) o.status = STATUS_MISS;
        else if (held_keys.size() >= KEY_CAPACITY) o.status = STATUS_FULL;
        else begin
          held_keys.insert(pos, k);
          o.status = STATUS_DONE;
        end
      end
      FUNC_DELETE: begin
        if (!hit) o.status = STATUS_MISS;
        else begin
          held_keys.delete(pos);
          o.status = STATUS_DONE;
        end
      end
      default: o.status = hit ? STATUS_DONE : STATUS_MISS;
    endcase
    o.count = 7'(held_keys.size());
    if (held_keys.size() == 0) begin
      o.smallest_key = '0;
      o.largest_key = '0;
      o.is_empty = 1'b1;
    end else begin
      o.smallest_key = held_keys[0];
      o.largest_key = held_keys[held_keys.size() - 1];
      o.is_empty = 1'b0;
    end
    return o;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_op(input logic [1:0] f, input logic signed [31:0] k);
    int gap;
    req_t r;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 24);
    end
    burst_left--;
    r.func = f;
    r.key = k;
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    set_rsp_q.push_back(apply_set_op(r));
    @(negedge clk);
  endtask

  task automatic wait_drained(input int settle);
    req_valid <= 1'b0;
    burst_left = 0;
    while (set_rsp_q.size() > 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_key();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45 && held_keys.size() > 0)
      return held_keys[$urandom_range(0, held_keys.size() - 1)];
    if (sel < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic signed [31:0] absent_key();
    logic signed [31:0] k;
    bit held;
    do begin
      k = $urandom;
      held = 1'b0;
      foreach (held_keys[i]) if (held_keys[i] == k) held = 1'b1;
    end while (held);
    return k;
  endfunction

  // Receiver: stall pattern is redrawn at random whenever its mode counter runs out; a requested hold-off wins.
  int stall_mode = 0;
  int mode_cycles = 0;
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      rsp_stall <= 1'b1;
    end else begin
      if (mode_cycles == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_cycles = 50;
      end
      mode_cycles--;
      case (stall_mode)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 3) == 0);
        2: rsp_stall <= ($urandom_range(0, 9) < 6);
        default: rsp_stall <= ~rsp_stall;
      endcase
    end
  end

  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (set_rsp_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected response: status=%0d count=%0d", rsp.status, rsp.count);
      end else begin
        want = set_rsp_q.pop_front();
        if (rsp.status !== want.status || rsp.count !== want.count ||
            rsp.smallest_key !== want.smallest_key ||
            rsp.largest_key !== want.largest_key || rsp.is_empty !== want.is_empty) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: exp status=%0d count=%0d min=%0d max=%0d empty=%0d",
                     want.status, want.count, want.smallest_key, want.largest_key,
                     want.is_empty, " got status=%0d count=%0d min=%0d max=%0d empty=%0d",
                     rsp.status, rsp.count, rsp.smallest_key,
                     rsp.largest_key, rsp.is_empty);
        end
      end
    end
  end

  task automatic test_edge_keys();
    send_op(FUNC_SEARCH, 32'sd0);               // lookups on an empty store
    send_op(FUNC_DELETE, 32'sd5);
    send_op(FUNC_SPARE, 32'sd0);
    send_op(FUNC_INSERT, 32'sd0);
    send_op(FUNC_INSERT, 32'sh7fff_ffff);
    send_op(FUNC_INSERT, 32'sh8000_0000);
    send_op(FUNC_INSERT, -32'sd1);
    send_op(FUNC_INSERT, 32'sd1);
    send_op(FUNC_INSERT, 32'sd0);               // duplicates
    send_op(FUNC_INSERT, 32'sh7fff_ffff);
    send_op(FUNC_SEARCH, 32'sh8000_0000);
    send_op(FUNC_SEARCH, 32'sd2);
    send_op(FUNC_SPARE, -32'sd1);
    send_op(FUNC_SPARE, 32'sd2);
    send_op(FUNC_DELETE, 32'sh8000_0000);       // smallest
    send_op(FUNC_DELETE, 32'sh7fff_ffff);       // largest
    send_op(FUNC_DELETE, 32'sd0);               // middle
    send_op(FUNC_DELETE, 32'sd0);
    send_op(FUNC_INSERT, 32'sh5555_5555);
    send_op(FUNC_INSERT, 32'shaaaa_aaaa);
    send_op(FUNC_DELETE, 32'sh5555_5555);
    send_op(FUNC_DELETE, 32'shaaaa_aaaa);
    send_op(FUNC_DELETE, 32'sd1);
    send_op(FUNC_DELETE, -32'sd1);              // back to empty
    wait_drained(4);
  endtask

  task automatic test_fill_to_capacity();
    logic signed [31:0] k;
    while (held_keys.size() < KEY_CAPACITY) send_op(FUNC_INSERT, pick_key());
    k = absent_key();
    send_op(FUNC_INSERT, k);                    // full
    send_op(FUNC_INSERT, held_keys[$urandom_range(0, KEY_CAPACITY - 1)]);
    send_op(FUNC_SEARCH, k);
    send_op(FUNC_SPARE, held_keys[0]);
    wait_drained(4);
  endtask

  task automatic test_output_hold_off();
    hold_off_cycles = 400;
    repeat (2) begin
      send_op(FUNC_DELETE, held_keys[$urandom_range(0, held_keys.size() - 1)]);
      send_op(FUNC_INSERT, absent_key());
      send_op(FUNC_SEARCH, pick_key());
      send_op(FUNC_INSERT, pick_key());
    end
    wait_drained(4);
  endtask

  task automatic run_churn(input int mode, input int n_ops);
    int sel;
    logic [1:0] f;
    repeat (n_ops) begin
      sel = $urandom_range(0, 99);
      case (mode)
        MODE_FILL:  f = (sel < 70) ? FUNC_INSERT : (sel < 80) ? FUNC_DELETE
                      : (sel < 97) ? FUNC_SEARCH : FUNC_SPARE;
        MODE_DRAIN: f = (sel < 10) ? FUNC_INSERT : (sel < 80) ? FUNC_DELETE
                      : (sel < 97) ? FUNC_SEARCH : FUNC_SPARE;
        default:    f = (sel < 35) ? FUNC_INSERT : (sel < 70) ? FUNC_DELETE
                      : (sel < 97) ? FUNC_SEARCH : FUNC_SPARE;
      endcase
      send_op(f, pick_key());
    end
  endtask

  task automatic test_random_churn();
    run_churn(MODE_FILL, 60);
    run_churn(MODE_MIXED, 50);
    run_churn(MODE_FILL, 60);
    wait_drained(4);
    run_churn(MODE_DRAIN, 60);
    run_churn(MODE_MIXED, 50);
  endtask

  task automatic test_drain_to_empty();
    while (held_keys.size() > 0)
      send_op(FUNC_DELETE, held_keys[$urandom_range(0, held_keys.size() - 1)]);
    send_op(FUNC_SEARCH, pick_key());
    send_op(FUNC_DELETE, pick_key());
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    key_pool[2] = 32'sh8000_0001;
    key_pool[3] = 32'sh7fff_fffe;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_edge_keys();
    test_fill_to_capacity();
    test_output_hold_off();
    test_random_churn();
    test_drain_to_empty();
    wait_drained(SETTLE_CYCLES);
    if (fail_count == 0) begin
      $display("** sorted_key_set: PASSED **");
    end else begin
      $display("** sorted_key_set: FAILED **");
    end
    $finish;
  end

endmodule
